FILE: rtl/core/bih_pkg.sv
// ----------------------------------------------------------------------------
// bih_pkg
// Shared types, codes and helpers for the block-instrument handshake core.
// ----------------------------------------------------------------------------
package bih_pkg;

  // box state coding, shared by the remote and local boxes
  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_CLEAR   = 2'd1,
    ST_TRAIN   = 2'd2,
    ST_BLOCKED = 2'd3
  } state_e;

  // op class codes
  localparam logic [2:0] OP_LONG_ON   = 3'd0;
  localparam logic [2:0] OP_SHORT_OFF = 3'd3;

  // incoming event ids
  localparam logic [3:0] EV_LOCK         = 4'd0;
  localparam logic [3:0] EV_CLEAR        = 4'd1;
  localparam logic [3:0] EV_TRAIN        = 4'd2;
  localparam logic [3:0] EV_CLEARED      = 4'd3;
  localparam logic [3:0] EV_CLEAR_ACK    = 4'd6;
  localparam logic [3:0] EV_TRAIN_ACK    = 4'd7;
  localparam logic [3:0] EV_CLEARED_ACK  = 4'd8;
  localparam logic [3:0] EV_CLEAR_REFUSE = 4'd9;
  localparam logic [3:0] EV_ID_LIMIT     = 4'd10;

  // outgoing event codes
  localparam logic [3:0] OUT_BLOCKED     = 4'd0;
  localparam logic [3:0] OUT_CLEAR_ACK   = 4'd1;
  localparam logic [3:0] OUT_TRAIN_ACK   = 4'd2;
  localparam logic [3:0] OUT_CLEARED_ACK = 4'd3;
  localparam logic [3:0] OUT_BELL        = 4'd4;
  localparam logic [3:0] OUT_CLEAR       = 4'd6;
  localparam logic [3:0] OUT_TRAIN       = 4'd7;
  localparam logic [3:0] OUT_CLEARED     = 4'd8;

  // local switch ids
  localparam logic [1:0] SW_LINE_CLEAR = 2'd0;
  localparam logic [1:0] SW_TRAIN      = 2'd1;
  localparam logic [1:0] SW_NORMAL     = 2'd2;
  localparam logic [1:0] SW_BELL       = 2'd3;

  // item kinds
  localparam logic KIND_BUS = 1'b0;

  // clear lamp codes
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_ON    = 2'd1;
  localparam logic [1:0] LAMP_BLINK = 2'd2;

  // command queue geometry
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one classified item: up to three sends plus the state after the item
  typedef struct packed {
    logic [1:0]      n_send;
    logic [2:0][3:0] ev;
    logic [2:0]      lv;
    state_e          rem;
    state_e          loc;
  } bih_cmd_t;

  function automatic logic [1:0] clear_lamp(state_e st);
    logic [1:0] lamp;
    lamp = LAMP_OFF;
    if (st == ST_CLEAR) lamp = LAMP_ON;
    else if (st == ST_BLOCKED) lamp = LAMP_BLINK;
    return lamp;
  endfunction

endpackage

FILE: rtl/core/bih_front.sv
// ----------------------------------------------------------------------------
// bih_front
// Accepts items, steps the box state machines and builds the send list.
// ----------------------------------------------------------------------------
module bih_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              item_kind_i,
  input  logic [2:0]        op_class_i,
  input  logic [3:0]        event_id_i,
  input  logic [1:0]        switch_id_i,
  input  logic              switch_pressed_i,
  output bih_pkg::bih_cmd_t cmd_o
);
  import bih_pkg::*;

  state_e rem_q, rem_d;
  state_e loc_q, loc_d;
  logic   lock_q, lock_d;
  logic   rm_go;

  // classify the item and compute the next state and sends
  always_comb begin
    lock_d = lock_q;
    rem_d  = rem_q;
    loc_d  = loc_q;
    rm_go  = 1'b0;
    cmd_o  = '0;

    if (item_kind_i == KIND_BUS) begin
      if (op_class_i <= OP_SHORT_OFF && event_id_i < EV_ID_LIMIT) begin
        case (event_id_i)
          EV_LOCK: begin
            lock_d = (op_class_i != OP_LONG_ON);
            rm_go  = 1'b1;
          end
          EV_CLEAR, EV_TRAIN, EV_CLEARED: begin
            rm_go = (op_class_i == OP_LONG_ON);
          end
          EV_CLEAR_ACK:    loc_d = ST_CLEAR;
          EV_TRAIN_ACK:    loc_d = ST_TRAIN;
          EV_CLEARED_ACK:  loc_d = ST_NORMAL;
          EV_CLEAR_REFUSE: loc_d = ST_BLOCKED;
          default: ;
        endcase
      end

      // remote box state machine
      if (rm_go) begin
        case (rem_q)
          ST_NORMAL: begin
            if (event_id_i == EV_CLEAR) begin
              if (lock_d) begin
                rem_d         = ST_CLEAR;
                cmd_o.n_send  = 2'd2;
                cmd_o.ev[0]   = OUT_CLEARED_ACK;
                cmd_o.ev[1]   = OUT_CLEAR_ACK;
                cmd_o.lv      = 3'b010;
              end else begin
                rem_d         = ST_BLOCKED;
                cmd_o.n_send  = 2'd1;
                cmd_o.ev[0]   = OUT_BLOCKED;
                cmd_o.lv      = 3'b001;
              end
            end
          end
          ST_CLEAR: begin
            if (event_id_i == EV_TRAIN) begin
              rem_d         = ST_TRAIN;
              cmd_o.n_send  = 2'd2;
              cmd_o.ev[0]   = OUT_CLEAR_ACK;
              cmd_o.ev[1]   = OUT_TRAIN_ACK;
              cmd_o.lv      = 3'b010;
            end
          end
          ST_TRAIN: begin
            if (event_id_i == EV_CLEARED) begin
              rem_d         = ST_NORMAL;
              cmd_o.n_send  = 2'd2;
              cmd_o.ev[0]   = OUT_TRAIN_ACK;
              cmd_o.ev[1]   = OUT_CLEARED_ACK;
              cmd_o.lv      = 3'b010;
            end
          end
          default: begin
            // releasing the lock completes a refused request
            if (lock_d) begin
              rem_d         = ST_CLEAR;
              cmd_o.n_send  = 2'd3;
              cmd_o.ev[0]   = OUT_BLOCKED;
              cmd_o.ev[1]   = OUT_CLEARED_ACK;
              cmd_o.ev[2]   = OUT_CLEAR_ACK;
              cmd_o.lv      = 3'b100;
            end
          end
        endcase
      end
    end else begin
      // local switch handling
      if (switch_id_i == SW_BELL) begin
        cmd_o.n_send = 2'd1;
        cmd_o.ev[0]  = OUT_BELL;
        cmd_o.lv     = {2'b00, switch_pressed_i};
      end else if (switch_pressed_i) begin
        if (loc_q == ST_NORMAL && switch_id_i == SW_LINE_CLEAR) begin
          cmd_o.n_send = 2'd2;
          cmd_o.ev[0]  = OUT_CLEARED;
          cmd_o.ev[1]  = OUT_CLEAR;
          cmd_o.lv     = 3'b010;
        end else if (loc_q == ST_CLEAR && switch_id_i == SW_TRAIN) begin
          cmd_o.n_send = 2'd2;
          cmd_o.ev[0]  = OUT_CLEAR;
          cmd_o.ev[1]  = OUT_TRAIN;
          cmd_o.lv     = 3'b010;
        end else if (loc_q == ST_TRAIN && switch_id_i == SW_NORMAL) begin
          cmd_o.n_send = 2'd2;
          cmd_o.ev[0]  = OUT_TRAIN;
          cmd_o.ev[1]  = OUT_CLEARED;
          cmd_o.lv     = 3'b010;
        end
      end
    end

    cmd_o.rem = rem_d;
    cmd_o.loc = loc_d;
  end

  // box state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= ST_NORMAL;
      loc_q  <= ST_NORMAL;
      lock_q <= 1'b1;
    end else if (accept_i) begin
      rem_q  <= rem_d;
      loc_q  <= loc_d;
      lock_q <= lock_d;
    end
  end

endmodule

FILE: rtl/core/bih_queue.sv
// ----------------------------------------------------------------------------
// bih_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bih_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bih_pkg::bih_cmd_t push_data_i,
  input  logic              pop_i,
  output bih_pkg::bih_cmd_t head_o,
  output logic              empty_o,
  output logic              full_o
);
  import bih_pkg::*;

  bih_cmd_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign head_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: rtl/core/bih_back.sv
// ----------------------------------------------------------------------------
// bih_back
// Walks the sends of each queued command and drives the result register.
// ----------------------------------------------------------------------------
module bih_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bih_pkg::bih_cmd_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              send_valid_o,
  output logic [3:0]        out_event_o,
  output logic              out_level_o,
  output logic              last_result_o,
  output logic [1:0]        remote_state_out_o,
  output logic [1:0]        local_state_out_o,
  output logic [1:0]        remote_clear_lamp_o,
  output logic [1:0]        local_clear_lamp_o,
  output logic              warn_lamp_o,
  output logic              occupied_lamp_o
);
  import bih_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q;
  logic       load;
  logic       send;
  logic [1:0] last_idx;
  logic       is_last;

  // result sequencing
  assign load     = !empty_i && (!vld_q || !out_stall_i);
  assign send     = (head_i.n_send != 2'd0);
  assign last_idx = send ? head_i.n_send - 2'd1 : 2'd0;
  assign is_last  = (idx_q == last_idx);
  assign pop_o    = load && is_last;
  assign idx_d    = is_last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (load) idx_q <= idx_d;
      if (load) vld_q <= 1'b1;
      else if (!out_stall_i) vld_q <= 1'b0;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      send_valid_o        <= send;
      out_event_o         <= send ? head_i.ev[idx_q] : 4'd0;
      out_level_o         <= send ? head_i.lv[idx_q] : 1'b0;
      last_result_o       <= is_last;
      remote_state_out_o  <= head_i.rem;
      local_state_out_o   <= head_i.loc;
      remote_clear_lamp_o <= clear_lamp(head_i.rem);
      local_clear_lamp_o  <= clear_lamp(head_i.loc);
      warn_lamp_o         <= (head_i.rem == ST_BLOCKED);
      occupied_lamp_o     <= (head_i.rem == ST_CLEAR) || (head_i.rem == ST_TRAIN);
    end
  end

  assign out_valid_o = vld_q;

endmodule

FILE: rtl/core/block_instrument_handshake_core.sv
// ----------------------------------------------------------------------------
// block_instrument_handshake_core
// Block-instrument handshake: bus events and local switches to sends and lamps.
// ----------------------------------------------------------------------------
// Path: an item is written into the command queue on its transfer; its first
//   result loads into the free result register once no item is ahead of it.
// Throughput: one item per cycle in unless the queue is full; one result per
//   cycle out unless stalled; an item produces 1 to 3 results in turn.
// A two-entry command queue decouples input transfers from result transfers.
// Reset: boxes return to normal, commutator released, queue and output empty.
module block_instrument_handshake_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       item_kind_i,
  input  logic [2:0] op_class_i,
  input  logic [3:0] event_id_i,
  input  logic [1:0] switch_id_i,
  input  logic       switch_pressed_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       send_valid_o,
  output logic [3:0] out_event_o,
  output logic       out_level_o,
  output logic       last_result_o,
  output logic [1:0] remote_state_out_o,
  output logic [1:0] local_state_out_o,
  output logic [1:0] remote_clear_lamp_o,
  output logic [1:0] local_clear_lamp_o,
  output logic       warn_lamp_o,
  output logic       occupied_lamp_o
);
  import bih_pkg::*;

  bih_cmd_t cmd;
  bih_cmd_t head;
  logic     accept;
  logic     q_full;
  logic     q_empty;
  logic     pop;

  // input transfer
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bih_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .item_kind_i      (item_kind_i),
    .op_class_i       (op_class_i),
    .event_id_i       (event_id_i),
    .switch_id_i      (switch_id_i),
    .switch_pressed_i (switch_pressed_i),
    .cmd_o            (cmd)
  );

  bih_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  bih_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .empty_i             (q_empty),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .send_valid_o        (send_valid_o),
    .out_event_o         (out_event_o),
    .out_level_o         (out_level_o),
    .last_result_o       (last_result_o),
    .remote_state_out_o  (remote_state_out_o),
    .local_state_out_o   (local_state_out_o),
    .remote_clear_lamp_o (remote_clear_lamp_o),
    .local_clear_lamp_o  (local_clear_lamp_o),
    .warn_lamp_o         (warn_lamp_o),
    .occupied_lamp_o     (occupied_lamp_o)
  );

endmodule

FILE: verif/bih_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bih_checker
// Watches both channels of the block-instrument handshake core, predicts the
// results of every input transfer from its own copy of the box states and
// compares each result transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module bih_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       item_kind_i,
  input  logic [2:0] op_class_i,
  input  logic [3:0] event_id_i,
  input  logic [1:0] switch_id_i,
  input  logic       switch_pressed_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       send_valid_i,
  input  logic [3:0] out_event_i,
  input  logic       out_level_i,
  input  logic       last_result_i,
  input  logic [1:0] remote_state_out_i,
  input  logic [1:0] local_state_out_i,
  input  logic [1:0] remote_clear_lamp_i,
  input  logic [1:0] local_clear_lamp_i,
  input  logic       warn_lamp_i,
  input  logic       occupied_lamp_i,
  output int         errors_o,
  output int         pending_o,
  output int         items_o,
  output int         results_o
);
  import bih_pkg::*;

  // one result transfer as seen on the output channel
  typedef struct packed {
    logic       send;
    logic [3:0] ev;
    logic       lv;
    logic       last;
    logic [1:0] rem;
    logic [1:0] loc;
    logic [1:0] rem_lamp;
    logic [1:0] loc_lamp;
    logic       warn;
    logic       occ;
  } lamp_result_t;

  lamp_result_t expected_lamps_q[$];

  // predicted box states and commutator
  state_e     remote_box;
  state_e     local_box;
  logic       commutator_free;

  // sends collected for the item being predicted
  logic [3:0] send_ev [0:2];
  logic       send_lv [0:2];
  int         send_cnt;

  lamp_result_t seen_result;
  lamp_result_t want_result;

  function automatic void add_send(input logic [3:0] ev, input logic lv);
    if (send_cnt < 3) begin
      send_ev[send_cnt] = ev;
      send_lv[send_cnt] = lv;
      send_cnt++;
    end
  endfunction

  function automatic logic [1:0] lamp_of(input state_e st);
    case (st)
      ST_CLEAR:   return LAMP_ON;
      ST_BLOCKED: return LAMP_BLINK;
      default:    return LAMP_OFF;
    endcase
  endfunction

  // remote box machine, stepped by request and commutator events
  function automatic void step_remote(input logic [3:0] id);
    case (remote_box)
      ST_NORMAL: begin
        if (id == EV_CLEAR) begin
          if (commutator_free) begin
            remote_box = ST_CLEAR;
            add_send(OUT_CLEARED_ACK, 1'b0);
            add_send(OUT_CLEAR_ACK, 1'b1);
          end else begin
            remote_box = ST_BLOCKED;
            add_send(OUT_BLOCKED, 1'b1);
          end
        end
      end
      ST_CLEAR: begin
        if (id == EV_TRAIN) begin
          remote_box = ST_TRAIN;
          add_send(OUT_CLEAR_ACK, 1'b0);
          add_send(OUT_TRAIN_ACK, 1'b1);
        end
      end
      ST_TRAIN: begin
        if (id == EV_CLEARED) begin
          remote_box = ST_NORMAL;
          add_send(OUT_TRAIN_ACK, 1'b0);
          add_send(OUT_CLEARED_ACK, 1'b1);
        end
      end
      default: begin
        // refused request completes once the commutator is released
        if (commutator_free) begin
          remote_box = ST_CLEAR;
          add_send(OUT_BLOCKED, 1'b0);
          add_send(OUT_CLEARED_ACK, 1'b0);
          add_send(OUT_CLEAR_ACK, 1'b1);
        end
      end
    endcase
  endfunction

  // work out the results of one input transfer and queue them
  function automatic void predict_item(input logic kind, input logic [2:0] op,
                                       input logic [3:0] id, input logic [1:0] sw,
                                       input logic pressed);
    lamp_result_t r;
    int           count;
    send_cnt = 0;
    if (kind == KIND_BUS) begin
      // other opcodes and large ids are dropped
      if (op <= OP_SHORT_OFF && id < EV_ID_LIMIT) begin
        case (id)
          EV_LOCK: begin
            commutator_free = (op != OP_LONG_ON);
            step_remote(id);
          end
          EV_CLEAR, EV_TRAIN, EV_CLEARED: begin
            if (op == OP_LONG_ON) step_remote(id);
          end
          EV_CLEAR_ACK:    local_box = ST_CLEAR;
          EV_TRAIN_ACK:    local_box = ST_TRAIN;
          EV_CLEARED_ACK:  local_box = ST_NORMAL;
          EV_CLEAR_REFUSE: local_box = ST_BLOCKED;
          default: ;
        endcase
      end
    end else if (sw == SW_BELL) begin
      add_send(OUT_BELL, pressed);
    end else if (pressed) begin
      // a press only counts when it matches the local box state
      if (local_box == ST_NORMAL && sw == SW_LINE_CLEAR) begin
        add_send(OUT_CLEARED, 1'b0);
        add_send(OUT_CLEAR, 1'b1);
      end else if (local_box == ST_CLEAR && sw == SW_TRAIN) begin
        add_send(OUT_CLEAR, 1'b0);
        add_send(OUT_TRAIN, 1'b1);
      end else if (local_box == ST_TRAIN && sw == SW_NORMAL) begin
        add_send(OUT_TRAIN, 1'b0);
        add_send(OUT_CLEARED, 1'b1);
      end
    end

    count = (send_cnt == 0) ? 1 : send_cnt;
    for (int k = 0; k < count; k++) begin
      r.send     = (send_cnt != 0);
      r.ev       = r.send ? send_ev[k] : 4'd0;
      r.lv       = r.send ? send_lv[k] : 1'b0;
      r.last     = (k == count - 1);
      r.rem      = remote_box;
      r.loc      = local_box;
      r.rem_lamp = lamp_of(remote_box);
      r.loc_lamp = lamp_of(local_box);
      r.warn     = (remote_box == ST_BLOCKED);
      r.occ      = (remote_box == ST_CLEAR || remote_box == ST_TRAIN);
      expected_lamps_q.push_back(r);
    end
  endfunction

  function automatic string fmt_result(input lamp_result_t r);
    return $sformatf({"send=%0d ev=%0d lv=%0d last=%0d rem=%0d loc=%0d",
                      " rlamp=%0d llamp=%0d warn=%0d occ=%0d"},
                     r.send, r.ev, r.lv, r.last, r.rem, r.loc, r.rem_lamp, r.loc_lamp,
                     r.warn, r.occ);
  endfunction

  // monitor both channels on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_box      = ST_NORMAL;
      local_box       = ST_NORMAL;
      commutator_free = 1'b1;
      send_cnt        = 0;
      expected_lamps_q.delete();
      errors_o        = 0;
      pending_o       = 0;
      items_o         = 0;
      results_o       = 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        seen_result = {send_valid_i, out_event_i, out_level_i, last_result_i,
                       remote_state_out_i, local_state_out_i, remote_clear_lamp_i,
                       local_clear_lamp_i, warn_lamp_i, occupied_lamp_i};
        if (expected_lamps_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result transfer: %s", $realtime,
                     fmt_result(seen_result));
        end else begin
          want_result = expected_lamps_q.pop_front();
          if (seen_result !== want_result) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", fmt_result(want_result));
              $display("  actual   %s", fmt_result(seen_result));
            end
          end
        end
      end
      // input transfer
      if (in_valid_i && !in_stall_i) begin
        items_o++;
        predict_item(item_kind_i, op_class_i, event_id_i, switch_id_i, switch_pressed_i);
      end
      pending_o = expected_lamps_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bus events and switch changes into the block-instrument handshake
// core: a directed pass over the corner cases, then random handshake
// sequences with random idling, a long output hold and a drain pause. The
// checker beside the core predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import bih_pkg::*;

  localparam logic       KIND_SWITCH = ~KIND_BUS;
  localparam logic [2:0] OP_LONG_OFF = 3'd1;
  localparam logic [2:0] OP_SHORT_ON = 3'd2;
  localparam logic [2:0] OP_OTHER    = 3'd4;
  localparam logic [3:0] EV_BELL     = 4'd4;
  localparam logic [3:0] EV_RESET    = 4'd5;
  localparam int         HOLD_CYCLES = 120;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic       item_kind      = 1'b0;
  logic [2:0] op_class       = '0;
  logic [3:0] event_id       = '0;
  logic [1:0] switch_id      = '0;
  logic       switch_pressed = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic       send_valid;
  logic [3:0] out_event;
  logic       out_level;
  logic       last_result;
  logic [1:0] remote_state_out;
  logic [1:0] local_state_out;
  logic [1:0] remote_clear_lamp;
  logic [1:0] local_clear_lamp;
  logic       warn_lamp;
  logic       occupied_lamp;

  int         errors;
  int         pending;
  int         items_done;
  int         results_done;

  // idling controls shared between sender and receiver
  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;
  logic       hold_req = 1'b0;

  block_instrument_handshake_core dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .item_kind_i         (item_kind),
    .op_class_i          (op_class),
    .event_id_i          (event_id),
    .switch_id_i         (switch_id),
    .switch_pressed_i    (switch_pressed),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .send_valid_o        (send_valid),
    .out_event_o         (out_event),
    .out_level_o         (out_level),
    .last_result_o       (last_result),
    .remote_state_out_o  (remote_state_out),
    .local_state_out_o   (local_state_out),
    .remote_clear_lamp_o (remote_clear_lamp),
    .local_clear_lamp_o  (local_clear_lamp),
    .warn_lamp_o         (warn_lamp),
    .occupied_lamp_o     (occupied_lamp)
  );

  bih_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .item_kind_i         (item_kind),
    .op_class_i          (op_class),
    .event_id_i          (event_id),
    .switch_id_i         (switch_id),
    .switch_pressed_i    (switch_pressed),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .send_valid_i        (send_valid),
    .out_event_i         (out_event),
    .out_level_i         (out_level),
    .last_result_i       (last_result),
    .remote_state_out_i  (remote_state_out),
    .local_state_out_i   (local_state_out),
    .remote_clear_lamp_i (remote_clear_lamp),
    .local_clear_lamp_i  (local_clear_lamp),
    .warn_lamp_i         (warn_lamp),
    .occupied_lamp_i     (occupied_lamp),
    .errors_o            (errors),
    .pending_o           (pending),
    .items_o             (items_done),
    .results_o           (results_done)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected", pending);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (!rx_quiet && $urandom_range(99) < 29);
    end
  end

  // offer one item, idling first at random, and wait for its transfer
  task automatic drive_item(input logic kind, input logic [2:0] op, input logic [3:0] id,
                            input logic [1:0] sw, input logic pressed);
    logic stalled;
    while (!tx_quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    item_kind      <= kind;
    op_class       <= op;
    event_id       <= id;
    switch_id      <= sw;
    switch_pressed <= pressed;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // mostly well-formed handshake traffic, with some noise
  task automatic random_item();
    int         pick;
    logic       kind;
    logic [2:0] op;
    logic [3:0] id;
    logic [1:0] sw;
    logic       pressed;
    pick    = $urandom_range(99);
    kind    = KIND_BUS;
    op      = OP_LONG_ON;
    id      = EV_CLEAR;
    sw      = 2'($urandom_range(3));
    pressed = 1'($urandom_range(1));
    if (pick < 15) begin
      kind = 1'($urandom_range(1));
      op   = 3'($urandom_range(7));
      id   = 4'($urandom_range(15));
    end else if (pick < 55) begin
      // lock, clear, train and cleared requests
      id = 4'($urandom_range(3));
      if ($urandom_range(3) == 0) op = 3'($urandom_range(3));
    end else if (pick < 72) begin
      // acknowledgements and refusal
      id = 4'(EV_CLEAR_ACK + $urandom_range(3));
      op = 3'($urandom_range(3));
    end else begin
      kind    = KIND_SWITCH;
      op      = 3'($urandom_range(7));
      id      = 4'($urandom_range(15));
      pressed = ($urandom_range(3) != 0);
    end
    drive_item(kind, op, id, sw, pressed);
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored traffic: other opcodes, large ids, bell and reset events, a long-off clear
    drive_item(KIND_BUS, OP_OTHER, EV_CLEAR, '0, 1'b0);
    drive_item(KIND_BUS, '1, EV_CLEAR, '1, 1'b1);
    drive_item(KIND_BUS, OP_LONG_ON, '1, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_ID_LIMIT, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_BELL, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_RESET, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_OFF, EV_CLEAR, '0, 1'b0);
    // full remote cycle: clear, train, cleared
    drive_item(KIND_BUS, OP_LONG_ON, EV_CLEAR, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_TRAIN, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_CLEARED, '0, 1'b0);
    // refused request while locked, completed by the release
    drive_item(KIND_BUS, OP_LONG_ON, EV_LOCK, '0, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_CLEAR, '0, 1'b0);
    drive_item(KIND_BUS, OP_SHORT_ON, EV_LOCK, '0, 1'b0);
    // local box: blocked press, then the full switch sequence
    drive_item(KIND_BUS, OP_SHORT_OFF, EV_CLEAR_REFUSE, '0, 1'b0);
    drive_item(KIND_SWITCH, '0, '0, SW_LINE_CLEAR, 1'b1);
    drive_item(KIND_BUS, OP_LONG_OFF, EV_CLEARED_ACK, '0, 1'b0);
    drive_item(KIND_SWITCH, '0, '0, SW_LINE_CLEAR, 1'b1);
    drive_item(KIND_SWITCH, '0, '0, SW_LINE_CLEAR, 1'b0);
    drive_item(KIND_BUS, OP_LONG_ON, EV_CLEAR_ACK, '0, 1'b0);
    drive_item(KIND_SWITCH, '0, '0, SW_TRAIN, 1'b1);
    drive_item(KIND_BUS, OP_LONG_ON, EV_TRAIN_ACK, '0, 1'b0);
    drive_item(KIND_SWITCH, '0, '0, SW_NORMAL, 1'b1);
    drive_item(KIND_SWITCH, '1, '1, SW_BELL, 1'b1);
    drive_item(KIND_SWITCH, '0, '0, SW_BELL, 1'b0);
    drive_item(KIND_SWITCH, '0, '0, SW_TRAIN, 1'b1);

    // random traffic with idling on both sides
    repeat (80) random_item();

    // stretch with no idling at all
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (40) random_item();

    // long result hold while items keep coming
    rx_quiet = 1'b0;
    hold_req = 1'b1;
    repeat (20) random_item();
    tx_quiet = 1'b0;

    // sender pause until all results are out
    drain_results();

    repeat (65) random_item();

    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d input transfers and %0d result transfers over directed corner cases,",
             items_done, results_done);
    $display("random handshake traffic, a %0d-cycle output hold and a full drain pause",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
